// ===== design/scq_pkg.sv =====
// Shared types and constants for the per-client sequence checker.
`default_nettype none

package scq_pkg;

  // Number of client entries in the associative table.
  localparam int TABLE_ENTRIES = 16;
  // Width of an index into the table (at least one bit).
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // Width of the fill count, which must hold TABLE_ENTRIES itself.
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  // Width of the reported entry index field.
  localparam int ENTRY_IDX_W = 4;

  // Result codes.
  typedef enum logic [1:0] {
    ST_VALID        = 2'd0,
    ST_DUPLICATE    = 2'd1,
    ST_OUT_OF_ORDER = 2'd2,
    ST_TABLE_FULL   = 2'd3
  } status_t;

  // One request word.
  typedef struct packed {
    logic [31:0] client_addr;
    logic [31:0] seq_num;
  } in_word_t;

  // One result word.
  typedef struct packed {
    status_t                  status;
    logic                     entry_found;
    logic [ENTRY_IDX_W-1:0]   entry_index;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/scq_table.sv =====
// Client table with parallel key match, sequence check and entry allocation.
`default_nettype none

module scq_table
  import scq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  req,
  input  wire logic      req_fire,
  output out_word_t      result
);

  logic [31:0]       key_r   [TABLE_ENTRIES];
  logic [31:0]       seq_r   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used_r;
  logic [TABLE_ENTRIES-1:0] used_nxt;
  logic [CNT_W-1:0]  filled_r;
  logic [CNT_W-1:0]  filled_nxt;

  logic [TABLE_ENTRIES-1:0] hit;
  logic              any_hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [31:0]       hit_seq;
  logic [IDX_W-1:0]  ins_idx;
  logic              table_full;
  logic              is_next;
  logic              is_dup;
  logic              seq_is_one;
  logic              do_insert;
  logic              do_advance;

  // Compare the key against every used entry in parallel and select the hit.
  always_comb begin
    hit_idx = '0;
    hit_seq = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i] = used_r[i] && (key_r[i] == req.client_addr);
      if (hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_seq = hit_seq | seq_r[i];
      end
    end
  end

  assign any_hit    = |hit;
  assign table_full = (filled_r == CNT_W'(TABLE_ENTRIES));
  assign ins_idx    = filled_r[IDX_W-1:0];
  assign seq_is_one = (req.seq_num == 32'd1);

  // The next-number test is done at 33 bits so that it never wraps.
  assign is_next = ({1'b0, req.seq_num} == ({1'b0, hit_seq} + 33'd1));
  assign is_dup  = (req.seq_num <= hit_seq);

  assign do_advance = req_fire && any_hit && is_next;
  assign do_insert  = req_fire && !any_hit && seq_is_one && !table_full;

  // Decide the result word.
  always_comb begin
    result = '{status: ST_OUT_OF_ORDER, entry_found: 1'b0, entry_index: '0};
    priority if (any_hit) begin
      result.entry_found = 1'b1;
      result.entry_index = ENTRY_IDX_W'(hit_idx);
      priority if (is_next) begin
        result.status = ST_VALID;
      end else if (is_dup) begin
        result.status = ST_DUPLICATE;
      end else begin
        result.status = ST_OUT_OF_ORDER;
      end
    end else if (!seq_is_one) begin
      result.status = ST_OUT_OF_ORDER;
    end else if (table_full) begin
      result.status = ST_TABLE_FULL;
    end else begin
      result.status      = ST_VALID;
      result.entry_found = 1'b1;
      result.entry_index = ENTRY_IDX_W'(ins_idx);
    end
  end

  // Valid bits and fill count.
  always_comb begin
    used_nxt   = used_r;
    filled_nxt = filled_r;
    if (do_insert) begin
      used_nxt[ins_idx] = 1'b1;
      filled_nxt        = filled_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      filled_r <= '0;
    end else begin
      used_r   <= used_nxt;
      filled_r <= filled_nxt;
    end
  end

  // Entry payload: keys written on insert, sequence numbers on insert or advance.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (do_insert && (ins_idx == IDX_W'(i))) begin
        key_r[i] <= req.client_addr;
        seq_r[i] <= req.seq_num;
      end else if (do_advance && hit[i]) begin
        seq_r[i] <= req.seq_num;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/per_client_sequence_checker_top.sv =====
// Top level of the per-client sequence checker: input and result registers.
//
// Usage:
//   Request words (client address, sequence number) enter on the in_ channel
//   with a valid/ready handshake. Each request gives exactly one result word
//   (status, entry_found, entry_index) on the out_ channel, in order.
//   A request is captured in an input register; once the result register
//   is free or draining, the table match, sequence check and any table
//   update happen in one pass and the result is loaded into the output
//   register, which drives out_valid. While the receiver does not stall,
//   throughput is one word per cycle, set by the parallel match over all
//   table entries.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more request; in_ready falls once both are
//   full and rises as soon as the receiver takes the result.
//   Reset (rst_n low, synchronous) empties both registers, marks every
//   table entry unused and clears the fill count; the block is ready to
//   accept words as soon as reset ends.
`default_nettype none

module per_client_sequence_checker_top
  import scq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_data
);

  logic      req_vld_r;
  in_word_t  req_r;
  logic      res_vld_r;
  out_word_t res_r;
  out_word_t decision;
  logic      advance;

  // The held request moves on when the result register is free or draining.
  assign advance  = req_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !req_vld_r || advance;

  scq_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_r),
    .req_fire (advance),
    .result   (decision)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= decision;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire
